FILE: design/smpq_pkg.sv
// shared types and constants for the sorted minimum priority queue
// used by smpq_cell and sorted_min_priority_queue; no dependencies
`timescale 1ns / 1ps

package smpq_pkg;

  localparam int unsigned KeyW      = 32;
  localparam int unsigned FillW     = 5;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 40;
  localparam int unsigned DefCapacity = 16;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_e;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic enq;  // insert the new key, list not full
    logic deq;  // drop the head, list not empty
  } cell_ctrl_t;

endpackage

FILE: design/smpq_cell.sv
// one slot of the sorted key chain: holds a key, compares it with the
// incoming key and shifts with its neighbors; uses smpq_pkg
`timescale 1ns / 1ps

module smpq_cell (
  input  logic                              clk_i,
  input  smpq_pkg::cell_ctrl_t              ctrl_i,
  input  logic signed [smpq_pkg::KeyW-1:0]  new_key_i,
  input  logic                              valid_i,
  input  logic signed [smpq_pkg::KeyW-1:0]  left_key_i,
  input  logic                              left_ins_i,
  input  logic signed [smpq_pkg::KeyW-1:0]  right_key_i,
  output logic signed [smpq_pkg::KeyW-1:0]  key_o,
  output logic                              ins_o
);

  logic signed [smpq_pkg::KeyW-1:0] key_q, key_d;

  // new key belongs at or before this slot
  assign ins_o = !valid_i || (new_key_i < key_q);
  assign key_o = key_q;

  always_comb begin
    key_d = key_q;
    if (ctrl_i.enq && ins_o) begin
      key_d = left_ins_i ? left_key_i : new_key_i;
    end else if (ctrl_i.deq) begin
      key_d = right_key_i;
    end
  end

  // only slots below the fill count are ever read
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

FILE: design/sorted_min_priority_queue.sv
// top level of the sorted minimum priority queue: a chain of compare and
// shift cells plus a fill counter and an output register; uses smpq_pkg, smpq_cell
//
//   channel   dir  tdata                              tuser
//   s_axis    in   [31:0] key                         [0] func (0 enq, 1 deq)
//   m_axis    out  [31:0] removed_key, [36:32] fill   [1:0] status
//
// one item per cycle: every cell compares the incoming key in parallel and
// the whole chain shifts in the same cycle, the result registered at the same clock edge as the shift
// a stalled output beat holds s_axis_tready low until it is taken
// reset empties the queue by clearing the fill counter; keys are not cleared
`timescale 1ns / 1ps

module sorted_min_priority_queue #(
  parameter int unsigned CAPACITY = smpq_pkg::DefCapacity
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [smpq_pkg::InDataW-1:0]    s_axis_tdata,  // [31:0] key
  input  logic                            s_axis_tuser,  // [0] func
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [smpq_pkg::OutDataW-1:0]   m_axis_tdata,  // [31:0] removed_key, [36:32] fill
  output logic [smpq_pkg::StatusW-1:0]    m_axis_tuser   // [1:0] status
);

  localparam int unsigned OccW = $clog2(CAPACITY + 1);

  logic [OccW-1:0] occ_q, occ_d;
  logic            out_valid_q;
  logic signed [smpq_pkg::KeyW-1:0] out_key_q, out_key_d;
  smpq_pkg::status_e                out_status_q, out_status_d;
  logic [smpq_pkg::FillW-1:0]       out_fill_q, out_fill_d;

  logic beat_in, full, empty;
  logic signed [smpq_pkg::KeyW-1:0] new_key;
  smpq_pkg::cell_ctrl_t ctrl;

  logic signed [smpq_pkg::KeyW-1:0] key_w [CAPACITY];
  logic                             ins_w [CAPACITY];
  logic                             vld_w [CAPACITY];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign beat_in       = s_axis_tvalid && s_axis_tready;
  assign new_key       = s_axis_tdata[smpq_pkg::KeyW-1:0];
  assign full          = (occ_q == OccW'(CAPACITY));
  assign empty         = (occ_q == '0);

  assign ctrl.enq = beat_in && (s_axis_tuser == smpq_pkg::FUNC_ENQ) && !full;
  assign ctrl.deq = beat_in && (s_axis_tuser == smpq_pkg::FUNC_DEQ) && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [smpq_pkg::KeyW-1:0] left_key, right_key;
    logic                             left_ins;

    assign vld_w[i] = (occ_q > OccW'(i));

    if (i == 0) begin : g_head
      assign left_key = '0;
      assign left_ins = 1'b0;
    end else begin : g_body
      assign left_key = key_w[i-1];
      assign left_ins = ins_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_key = key_w[i];
    end else begin : g_inner
      assign right_key = key_w[i+1];
    end

    smpq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .new_key_i   (new_key),
      .valid_i     (vld_w[i]),
      .left_key_i  (left_key),
      .left_ins_i  (left_ins),
      .right_key_i (right_key),
      .key_o       (key_w[i]),
      .ins_o       (ins_w[i])
    );
  end

  always_comb begin
    occ_d        = occ_q;
    out_key_d    = '0;
    out_status_d = smpq_pkg::ST_OK;
    if (ctrl.enq) begin
      occ_d = occ_q + OccW'(1);
    end else if (ctrl.deq) begin
      occ_d     = occ_q - OccW'(1);
      out_key_d = key_w[0];
    end
    if (s_axis_tuser == smpq_pkg::FUNC_ENQ && full) begin
      out_status_d = smpq_pkg::ST_FULL;
    end else if (s_axis_tuser == smpq_pkg::FUNC_DEQ && empty) begin
      out_status_d = smpq_pkg::ST_EMPTY;
    end
    // fill wraps modulo 32 for large capacities
    out_fill_d = smpq_pkg::FillW'(occ_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (beat_in) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_in) begin
      out_key_q    <= out_key_d;
      out_status_q <= out_status_d;
      out_fill_q   <= out_fill_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(smpq_pkg::OutDataW - smpq_pkg::KeyW - smpq_pkg::FillW){1'b0}},
                          out_fill_q, out_key_q};
  assign m_axis_tuser  = out_status_q;

endmodule
